// ----- rtl/core/sha2_pkg.sv -----
// SHA-2 engine package: command/status types, byte-select and mode codes, round constants,
// initial hash values, rotates and the sigma functions. No dependencies.
package sha2_pkg;

    localparam logic [1:0] SEL_DATA  = 2'd0;
    localparam logic [1:0] SEL_PAD80 = 2'd1;
    localparam logic [1:0] SEL_ZERO  = 2'd2;
    localparam logic [1:0] SEL_LEN   = 2'd3;

    localparam logic [1:0] MODE_224 = 2'd0;
    localparam logic [1:0] MODE_256 = 2'd1;
    localparam logic [1:0] MODE_384 = 2'd2;
    localparam logic [1:0] MODE_512 = 2'd3;

    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic       absorb;
        logic [1:0] byte_sel;
        logic       count_bits;
        logic       round;
        logic       final_add;
        logic       emit;
    } sha2_cmd_t;

    typedef struct packed {
        logic block_full;
        logic len_start;
        logic round_last;
        logic out_last;
    } sha2_status_t;

    function automatic logic [63:0] k_const(input logic [6:0] t);
        logic [63:0] k;
        unique case (t)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'd0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] iv_long(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'h6a09e667f3bcc908;  3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;  3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;  3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;  default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] iv_short(input logic [2:0] i);
        logic [63:0] r;
        unique case (i)
            3'd0: r = 64'hcbbb9d5dc1059ed8;  3'd1: r = 64'h629a292a367cd507;
            3'd2: r = 64'h9159015a3070dd17;  3'd3: r = 64'h152fecd8f70e5939;
            3'd4: r = 64'h67332667ffc00b31;  3'd5: r = 64'h8eb44a8768581511;
            3'd6: r = 64'hdb0c2e0d64f98fa7;  default: r = 64'h47b5481dbefa4fa4;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] init_hash(input logic [1:0] mode, input logic [2:0] i);
        logic [63:0] r;
        unique case (mode)
            MODE_224: r = {32'd0, 32'(iv_short(i))};
            MODE_256: r = iv_long(i) >> 32;
            MODE_384: r = iv_short(i);
            default:  r = iv_long(i);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] lsig0(input logic [63:0] x, input logic wide);
        if (wide)
            return ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
        return {32'd0, ror32(x[31:0], 7) ^ ror32(x[31:0], 18) ^ (x[31:0] >> 3)};
    endfunction

    function automatic logic [63:0] lsig1(input logic [63:0] x, input logic wide);
        if (wide)
            return ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
        return {32'd0, ror32(x[31:0], 17) ^ ror32(x[31:0], 19) ^ (x[31:0] >> 10)};
    endfunction

    function automatic logic [63:0] bsig0(input logic [63:0] x, input logic wide);
        if (wide)
            return ror64(x, 28) ^ ror64(x, 34) ^ ror64(x, 39);
        return {32'd0, ror32(x[31:0], 2) ^ ror32(x[31:0], 13) ^ ror32(x[31:0], 22)};
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x, input logic wide);
        if (wide)
            return ror64(x, 14) ^ ror64(x, 18) ^ ror64(x, 41);
        return {32'd0, ror32(x[31:0], 6) ^ ror32(x[31:0], 11) ^ ror32(x[31:0], 25)};
    endfunction

endpackage

// ----- rtl/core/sha2_hash_engine.sv -----
// SHA-2 hash engine top level: controller plus datapath.
// Depends on sha2_pkg, sha2_ctrl and sha2_datapath.
//
// An item is taken when start is high and busy low. Each completed block runs
// one round per cycle through a single round unit: 64 rounds (SHA-224/256)
// or 80 (SHA-384/512), then an update of the chaining value, with busy high
// throughout. End of message adds the padding bytes, a pause before the
// length field, the extra block(s), and then the digest words on consecutive
// cycles, one per cycle with result_valid high and last_word on the final one.
// The receiver cannot stall results. Write hash_mode only while busy is low;
// it restarts the message.
module sha2_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hash_mode_we,
    input  logic [1:0]  hash_mode_wdata,
    input  logic        start,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        busy,
    output logic        result_valid,
    output logic [63:0] digest_word,
    output logic        last_word
);
    import sha2_pkg::*;

    sha2_cmd_t    cmd;
    sha2_status_t status;

    sha2_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .byte_valid     (byte_valid),
        .end_of_message (end_of_message),
        .status         (status),
        .cmd            (cmd),
        .busy           (busy),
        .result_valid   (result_valid)
    );

    sha2_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (hash_mode_we),
        .cfg_mode    (hash_mode_wdata),
        .data_byte   (data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

    assign last_word = result_valid & status.out_last;

`ifndef SYNTHESIS
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result without busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        last_word |=> !busy)
        else $error("engine still busy after last word");

    a_emit_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_word) |=> result_valid)
        else $error("digest read-out broken off");
`endif

endmodule

// ----- rtl/core/sha2_datapath.sv -----
// SHA-2 datapath: byte packing, schedule shift line, round logic, chaining
// value, bit counter and digest read-out. Depends on sha2_pkg.
module sha2_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_mode,
    input  logic [7:0]            data_byte,
    input  sha2_pkg::sha2_cmd_t   cmd,
    output sha2_pkg::sha2_status_t status,
    output logic [63:0]           digest_word
);
    import sha2_pkg::*;

    logic [1:0]  mode_reg;
    logic [63:0] bc_reg;
    logic [6:0]  pos_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  oidx_reg;
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] w_reg [16];
    logic [55:0] acc_reg;

    logic        wide;
    logic [63:0] mask;
    logic [7:0]  byte_in;
    logic [63:0] len_sh;
    logic        word_done;
    logic [63:0] word_in;
    logic [63:0] k_t;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] w_new;
    logic [63:0] bc_next;
    logic [2:0]  out_last_idx;

    assign wide = mode_reg[1];
    assign mask = wide ? '1 : MASK32;

    assign len_sh = bc_reg >> {~pos_reg[2:0], 3'b000};

    always_comb
    begin
        unique case (cmd.byte_sel)
            SEL_DATA:  byte_in = data_byte;
            SEL_PAD80: byte_in = 8'h80;
            SEL_ZERO:  byte_in = 8'h00;
            default:   byte_in = (wide && !pos_reg[3]) ? 8'h00 : len_sh[7:0];
        endcase
    end

    assign word_done = wide ? (pos_reg[2:0] == 3'd7) : (pos_reg[1:0] == 2'd3);
    assign word_in   = wide ? {acc_reg, byte_in} : {32'd0, acc_reg[23:0], byte_in};

    assign k_t   = wide ? k_const(rnd_reg) : {32'd0, 32'(k_const(rnd_reg) >> 32)};
    assign t1    = (v_reg[7] + bsig1(v_reg[4], wide)
                   + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + k_t + w_reg[0]) & mask;
    assign t2    = (bsig0(v_reg[0], wide)
                   + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2])))
                   & mask;
    assign w_new = (lsig1(w_reg[14], wide) + w_reg[9] + lsig0(w_reg[1], wide) + w_reg[0]) & mask;

    assign bc_next = (bc_reg > 64'hFFFF_FFFF_FFFF_FFF7) ? '1 : bc_reg + 64'd8;

    always_comb
    begin
        unique case (mode_reg)
            MODE_224: out_last_idx = 3'd6;
            MODE_384: out_last_idx = 3'd5;
            default:  out_last_idx = 3'd7;
        endcase
    end

    assign status.block_full = (pos_reg == (wide ? 7'd127 : 7'd63));
    assign status.len_start  = (pos_reg == (wide ? 7'd112 : 7'd56));
    assign status.round_last = (rnd_reg == (wide ? 7'd79 : 7'd63));
    assign status.out_last   = (oidx_reg == out_last_idx);

    assign digest_word = h_reg[oidx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_256;
            bc_reg   <= '0;
            pos_reg  <= '0;
            rnd_reg  <= '0;
            oidx_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(MODE_256, 3'(i));
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_mode;
            bc_reg   <= '0;
            pos_reg  <= '0;
            oidx_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= init_hash(cfg_mode, 3'(i));
        end
        else
        begin
            if (cmd.absorb)
            begin
                pos_reg <= status.block_full ? 7'd0 : pos_reg + 7'd1;
                if (status.block_full)
                    rnd_reg <= '0;
            end
            if (cmd.count_bits)
                bc_reg <= bc_next;
            if (cmd.round)
                rnd_reg <= rnd_reg + 7'd1;
            if (cmd.final_add)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= (h_reg[i] + v_reg[i]) & mask;
            end
            if (cmd.emit)
            begin
                if (status.out_last)
                begin
                    oidx_reg <= '0;
                    bc_reg   <= '0;
                    pos_reg  <= '0;
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= init_hash(mode_reg, 3'(i));
                end
                else
                    oidx_reg <= oidx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
        begin
            acc_reg <= {acc_reg[47:0], byte_in};
            if (word_done)
            begin
                for (int i = 0; i < 15; i++)
                    w_reg[i] <= w_reg[i + 1];
                w_reg[15] <= word_in;
            end
            if (status.block_full)
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
        end
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= (v_reg[3] + t1) & mask;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= (t1 + t2) & mask;
        end
    end

endmodule

// ----- rtl/core/sha2_ctrl.sv -----
// SHA-2 controller: sequences absorb, padding, rounds and digest read-out.
// Depends on sha2_pkg.
module sha2_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   byte_valid,
    input  logic                   end_of_message,
    input  sha2_pkg::sha2_status_t status,
    output sha2_pkg::sha2_cmd_t    cmd,
    output logic                   busy,
    output logic                   result_valid
);
    import sha2_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_PAD80 = 3'd3;
    localparam logic [2:0] S_PADZ  = 3'd4;
    localparam logic [2:0] S_PADL  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.byte_sel = SEL_DATA;
                if (start)
                begin
                    cmd.absorb     = byte_valid;
                    cmd.count_bits = byte_valid;
                    if (byte_valid && status.block_full)
                    begin
                        state_next = S_ROUND;
                        ret_next   = end_of_message ? S_PAD80 : S_IDLE;
                    end
                    else if (end_of_message)
                        state_next = S_PAD80;
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.final_add = 1'b1;
                state_next    = ret_reg;
            end
            S_PAD80:
            begin
                cmd.absorb   = 1'b1;
                cmd.byte_sel = SEL_PAD80;
                state_next   = status.block_full ? S_ROUND : S_PADZ;
                ret_next     = S_PADZ;
            end
            S_PADZ:
            begin
                cmd.byte_sel = SEL_ZERO;
                if (status.len_start)
                    state_next = S_PADL;
                else
                begin
                    cmd.absorb = 1'b1;
                    if (status.block_full)
                    begin
                        state_next = S_ROUND;
                        ret_next   = S_PADZ;
                    end
                end
            end
            S_PADL:
            begin
                cmd.absorb   = 1'b1;
                cmd.byte_sel = SEL_LEN;
                if (status.block_full)
                begin
                    state_next = S_ROUND;
                    ret_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.emit = 1'b1;
                if (status.out_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);

endmodule
